### hdl/pwc_pkg.sv
// ----------------------------------------------------------------------------
// pwc_pkg
// Shared types and constants for the power window controller.
// ----------------------------------------------------------------------------
package pwc_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int TICK_REG_W      = 16;
    localparam int CFG_INDEX_W     = 2;

    localparam logic [TICK_REG_W-1:0] HOLD_TICKS_RST = 16'd1000;
    localparam logic [TICK_REG_W-1:0] JAM_TICKS_RST  = 16'd2000;

    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TICKS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_JAM_TICKS  = 2'd1;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HOLD   = 2'd1,
        PH_MANUAL = 2'd2,
        PH_AUTO   = 2'd3
    } phase_t;

    typedef struct packed {
        logic drv_a_press;
        logic drv_b_press;
        logic pas_a_press;
        logic pas_b_press;
        logic limit_a_reached;
        logic limit_b_reached;
        logic jam_sensor_level;
        logic lock_switch_on;
    } in_item_t;

    typedef struct packed {
        logic motor_a_drive;
        logic motor_b_drive;
        logic lock_led;
    } out_item_t;

endpackage

### hdl/pwc_ctrl.sv
// ----------------------------------------------------------------------------
// pwc_ctrl
// Jam handling and run state machine; state advances once per item.
// ----------------------------------------------------------------------------
module pwc_ctrl
    import pwc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  in_item_t              item,
    input  logic [TICK_REG_W-1:0] hold_ticks,
    input  logic [TICK_REG_W-1:0] jam_ticks,
    output out_item_t             result
);

    localparam int CW = COUNT_WIDTH;
    localparam int LW = (CW > TICK_REG_W) ? CW : TICK_REG_W;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
    localparam logic [CW-1:0] CNT_ONE = CW'(1);

    phase_t        phase_reg, phase_next;
    logic          dir_reg, dir_next;
    logic          src_reg, src_next;
    logic [CW-1:0] hold_cnt_reg, hold_cnt_next;
    logic          muted_reg, muted_next;
    logic          jam_act_reg, jam_act_next;
    logic [CW-1:0] jam_cnt_reg, jam_cnt_next;
    logic          jam_pend_reg, jam_pend_next;
    logic          jam_prev_reg, jam_prev_next;

    logic [CW-1:0] hold_lim;
    logic [CW-1:0] jam_lim;
    logic          jam_edge;
    logic          btn;
    logic          lim;
    logic [3:0]    press;

    function automatic logic [CW-1:0] eff_limit(input logic [TICK_REG_W-1:0] r);
        logic [LW-1:0] v;
        logic [LW-1:0] m;
        v = (r == '0) ? LW'(1) : LW'(r);
        m = LW'(CNT_MAX);
        return (v > m) ? CNT_MAX : v[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
        return (c == CNT_MAX) ? c : c + CNT_ONE;
    endfunction

    assign hold_lim = eff_limit(hold_ticks);
    assign jam_lim  = eff_limit(jam_ticks);
    assign jam_edge = jam_prev_reg & ~item.jam_sensor_level;
    assign press    = {item.pas_b_press, item.pas_a_press, item.drv_b_press, item.drv_a_press};
    assign btn      = press[{src_reg, dir_reg}];
    assign lim      = dir_reg ? item.limit_b_reached : item.limit_a_reached;

    always_comb
    begin
        phase_next    = phase_reg;
        dir_next      = dir_reg;
        src_next      = src_reg;
        hold_cnt_next = hold_cnt_reg;
        muted_next    = muted_reg;
        jam_act_next  = jam_act_reg;
        jam_cnt_next  = jam_cnt_reg;
        jam_pend_next = jam_pend_reg;
        jam_prev_next = item.jam_sensor_level;

        if (jam_act_reg)
        begin
            if (jam_cnt_reg >= jam_lim)
            begin
                if (jam_pend_reg)
                begin
                    jam_pend_next = 1'b0;
                    jam_cnt_next  = CNT_ONE;
                end
                else
                begin
                    jam_act_next = 1'b0;
                    jam_cnt_next = '0;
                    if (phase_reg != PH_IDLE)
                    begin
                        muted_next = 1'b1;
                    end
                end
            end
            else
            begin
                jam_cnt_next = sat_inc(jam_cnt_reg);
            end
        end
        if (jam_edge)
        begin
            if (jam_act_next)
            begin
                jam_pend_next = 1'b1;
            end
            else
            begin
                jam_act_next = 1'b1;
                jam_cnt_next = CNT_ONE;
            end
        end

        case (phase_reg)
            PH_IDLE:
            begin
                if (press != 4'b0000)
                begin
                    phase_next    = PH_HOLD;
                    hold_cnt_next = '0;
                    muted_next    = 1'b0;
                    if (press[0])
                    begin
                        src_next = 1'b0;
                        dir_next = 1'b0;
                    end
                    else if (press[1])
                    begin
                        src_next = 1'b0;
                        dir_next = 1'b1;
                    end
                    else if (press[2])
                    begin
                        src_next = 1'b1;
                        dir_next = 1'b0;
                    end
                    else
                    begin
                        src_next = 1'b1;
                        dir_next = 1'b1;
                    end
                end
            end
            PH_HOLD:
            begin
                hold_cnt_next = sat_inc(hold_cnt_reg);
                if (hold_cnt_next >= hold_lim)
                begin
                    phase_next = btn ? PH_MANUAL : PH_AUTO;
                end
            end
            PH_MANUAL:
            begin
                if (lim || !btn)
                begin
                    phase_next = PH_IDLE;
                    muted_next = 1'b0;
                end
            end
            default:
            begin
                if (lim || btn)
                begin
                    phase_next = PH_IDLE;
                    muted_next = 1'b0;
                end
            end
        endcase
    end

    always_comb
    begin
        result.lock_led = item.lock_switch_on;
        if (jam_act_next)
        begin
            result.motor_a_drive = 1'b1;
            result.motor_b_drive = 1'b0;
        end
        else if (phase_next == PH_IDLE || muted_next)
        begin
            result.motor_a_drive = 1'b0;
            result.motor_b_drive = 1'b0;
        end
        else
        begin
            result.motor_a_drive = ~dir_next;
            result.motor_b_drive = dir_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            dir_reg      <= 1'b0;
            src_reg      <= 1'b0;
            hold_cnt_reg <= '0;
            muted_reg    <= 1'b0;
            jam_act_reg  <= 1'b0;
            jam_cnt_reg  <= '0;
            jam_pend_reg <= 1'b0;
            jam_prev_reg <= 1'b1;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            dir_reg      <= dir_next;
            src_reg      <= src_next;
            hold_cnt_reg <= hold_cnt_next;
            muted_reg    <= muted_next;
            jam_act_reg  <= jam_act_next;
            jam_cnt_reg  <= jam_cnt_next;
            jam_pend_reg <= jam_pend_next;
            jam_prev_reg <= jam_prev_next;
        end
    end

endmodule

### hdl/power_window_controller_unit.sv
// ----------------------------------------------------------------------------
// power_window_controller_unit
// Power window controller: one tick of switch levels in, motor and lamp out.
//
//   channel | signals                               | handshake
//   --------+---------------------------------------+----------------------
//   in      | drv/pas a/b press, limits, jam, lock  | in_valid / in_ready
//   out     | motor_a_drive, motor_b_drive, lock_led| out_valid / out_ready
//   cfg     | cfg_index, cfg_data                   | cfg_valid / cfg_ready
//
// Two stages: input register, then state update and result register.
// The result is registered behind the input register; one item per cycle is
// sustained while out_ready holds. The input register advances whenever the
// result register is empty or being drained; a waiting result blocks the
// input once the input register holds an item, so at most two items are in
// flight. Reset returns the run and jam machines to idle and the tick
// registers to 1000 and 2000. Configuration writes are always taken.
// ----------------------------------------------------------------------------
module power_window_controller_unit
    import pwc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   drv_a_press,
    input  logic                   drv_b_press,
    input  logic                   pas_a_press,
    input  logic                   pas_b_press,
    input  logic                   limit_a_reached,
    input  logic                   limit_b_reached,
    input  logic                   jam_sensor_level,
    input  logic                   lock_switch_on,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   motor_a_drive,
    output logic                   motor_b_drive,
    output logic                   lock_led,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [TICK_REG_W-1:0]  cfg_data
);

    in_item_t              item_reg;
    logic                  item_valid_reg, item_valid_next;
    out_item_t             res_reg;
    out_item_t             res_comb;
    logic                  out_valid_reg, out_valid_next;
    logic [TICK_REG_W-1:0] hold_ticks_reg;
    logic [TICK_REG_W-1:0] jam_ticks_reg;
    logic                  adv;

    assign adv       = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !item_valid_reg || adv;
    assign cfg_ready = 1'b1;

    assign item_valid_next = (in_valid && in_ready) ? 1'b1 : (adv ? 1'b0 : item_valid_reg);
    assign out_valid_next  = adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    pwc_ctrl #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (adv),
        .item       (item_reg),
        .hold_ticks (hold_ticks_reg),
        .jam_ticks  (jam_ticks_reg),
        .result     (res_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            hold_ticks_reg <= HOLD_TICKS_RST;
            jam_ticks_reg  <= JAM_TICKS_RST;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_HOLD_TICKS: hold_ticks_reg <= cfg_data;
                    REG_JAM_TICKS:  jam_ticks_reg  <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.drv_a_press      <= drv_a_press;
            item_reg.drv_b_press      <= drv_b_press;
            item_reg.pas_a_press      <= pas_a_press;
            item_reg.pas_b_press      <= pas_b_press;
            item_reg.limit_a_reached  <= limit_a_reached;
            item_reg.limit_b_reached  <= limit_b_reached;
            item_reg.jam_sensor_level <= jam_sensor_level;
            item_reg.lock_switch_on   <= lock_switch_on;
        end
        if (adv)
        begin
            res_reg <= res_comb;
        end
    end

    assign out_valid     = out_valid_reg;
    assign motor_a_drive = res_reg.motor_a_drive;
    assign motor_b_drive = res_reg.motor_b_drive;
    assign lock_led      = res_reg.lock_led;

endmodule

### bench/tb_power_window_controller_unit.sv
// ----------------------------------------------------------------------------
// tb_power_window_controller_unit
// Self-checking bench for the power window controller. Switch-level ticks
// come from a queue of pending items and are driven over a valid/ready
// channel. Each accepted tick runs through a behavioral copy of the run and
// jam machines, and every motor/lamp result is compared in order. Timing
// registers are reprogrammed between drained phases: reset values, zero,
// full scale and random small limits. Both sides idle at random, and one
// phase holds the output off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_power_window_controller_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import pwc_pkg::*;

    localparam int IDLE_PCT        = 31;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_LIMIT     = 50000;
    localparam int RUN_LIMIT       = 200000;
    localparam int MAX_REPORTS     = 40;
    localparam int LIMIT_PCT       = 6;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    logic                   clk;
    logic                   rst_n      = 1'b0;
    logic                   in_valid   = 1'b0;
    logic                   in_ready;
    in_item_t               drive_item = in_item_t'(8'b0000_0010);
    logic                   out_valid;
    logic                   out_ready  = 1'b0;
    logic                   motor_a_drive;
    logic                   motor_b_drive;
    logic                   lock_led;
    logic                   cfg_valid  = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index  = '0;
    logic [TICK_REG_W-1:0]  cfg_data   = '0;

    in_item_t  pending_ticks[$];
    out_item_t expected_drive[$];
    in_item_t  levels = in_item_t'(8'b0000_0010);

    int  ticks_queued      = 0;
    int  ticks_accepted    = 0;
    int  results_checked   = 0;
    int  mismatches        = 0;
    int  cfg_writes        = 0;
    int  cycle_count       = 0;
    int  stalls_requested  = 0;
    int  stalls_served     = 0;
    int  hold_off_left     = 0;
    bit  calm              = 1'b0;

    // behavioral copy of the controller state
    phase_t                     run_ph        = PH_IDLE;
    logic                       run_dir_b     = 1'b0;
    logic                       run_by_pas    = 1'b0;
    logic [COUNT_WIDTH_DEF-1:0] hold_cnt      = '0;
    logic                       muted         = 1'b0;
    logic                       jam_on        = 1'b0;
    logic [COUNT_WIDTH_DEF-1:0] jam_cnt       = '0;
    logic                       jam_queued    = 1'b0;
    logic                       jam_line_last = 1'b1;
    logic [TICK_REG_W-1:0]      hold_limit_reg = HOLD_TICKS_RST;
    logic [TICK_REG_W-1:0]      jam_limit_reg  = JAM_TICKS_RST;

    power_window_controller_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .drv_a_press      (drive_item.drv_a_press),
        .drv_b_press      (drive_item.drv_b_press),
        .pas_a_press      (drive_item.pas_a_press),
        .pas_b_press      (drive_item.pas_b_press),
        .limit_a_reached  (drive_item.limit_a_reached),
        .limit_b_reached  (drive_item.limit_b_reached),
        .jam_sensor_level (drive_item.jam_sensor_level),
        .lock_switch_on   (drive_item.lock_switch_on),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .motor_a_drive    (motor_a_drive),
        .motor_b_drive    (motor_b_drive),
        .lock_led         (lock_led),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [COUNT_WIDTH_DEF-1:0] tick_limit(input logic [TICK_REG_W-1:0] r);
        return (r == '0) ? COUNT_WIDTH_DEF'(1) : COUNT_WIDTH_DEF'(r);
    endfunction

    function automatic logic [COUNT_WIDTH_DEF-1:0] count_up(input logic [COUNT_WIDTH_DEF-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    function automatic out_item_t predict_drive(input in_item_t t);
        logic [3:0] press;
        logic       jam_fall;
        logic       btn;
        logic       lim;
        logic       found;
        out_item_t  r;
        press = {t.pas_b_press, t.pas_a_press, t.drv_b_press, t.drv_a_press};
        jam_fall = jam_line_last && !t.jam_sensor_level;
        jam_line_last = t.jam_sensor_level;
        if (jam_on)
        begin
            if (jam_cnt >= tick_limit(jam_limit_reg))
            begin
                if (jam_queued)
                begin
                    jam_queued = 1'b0;
                    jam_cnt = COUNT_WIDTH_DEF'(1);
                end
                else
                begin
                    jam_on = 1'b0;
                    jam_cnt = '0;
                    if (run_ph != PH_IDLE)
                        muted = 1'b1;
                end
            end
            else
                jam_cnt = count_up(jam_cnt);
        end
        if (jam_fall)
        begin
            if (jam_on)
                jam_queued = 1'b1;
            else
            begin
                jam_on = 1'b1;
                jam_cnt = COUNT_WIDTH_DEF'(1);
            end
        end

        btn = press[{run_by_pas, run_dir_b}];
        lim = run_dir_b ? t.limit_b_reached : t.limit_a_reached;
        found = 1'b0;
        case (run_ph)
            PH_IDLE:
                for (int i = 0; i < 4; i++)
                begin
                    if (press[i] && !found)
                    begin
                        found = 1'b1;
                        run_by_pas = i[1];
                        run_dir_b = i[0];
                        run_ph = PH_HOLD;
                        hold_cnt = '0;
                        muted = 1'b0;
                    end
                end
            PH_HOLD:
            begin
                hold_cnt = count_up(hold_cnt);
                if (hold_cnt >= tick_limit(hold_limit_reg))
                begin
                    if (btn)
                        run_ph = PH_MANUAL;
                    else
                        run_ph = PH_AUTO;
                end
            end
            PH_MANUAL:
                if (lim || !btn)
                begin
                    run_ph = PH_IDLE;
                    muted = 1'b0;
                end
            default:
                if (lim || btn)
                begin
                    run_ph = PH_IDLE;
                    muted = 1'b0;
                end
        endcase

        if (jam_on)
        begin
            r.motor_a_drive = 1'b1;
            r.motor_b_drive = 1'b0;
        end
        else if (run_ph == PH_IDLE || muted)
        begin
            r.motor_a_drive = 1'b0;
            r.motor_b_drive = 1'b0;
        end
        else
        begin
            r.motor_a_drive = !run_dir_b;
            r.motor_b_drive = run_dir_b;
        end
        r.lock_led = t.lock_switch_on;
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("MISMATCH @%0t result %0d: %s", $time, results_checked, what);
    endtask

    task automatic check_drive();
        out_item_t want;
        if (expected_drive.size() == 0)
        begin
            flag_mismatch("result with no tick waiting");
            return;
        end
        want = expected_drive.pop_front();
        if (motor_a_drive !== want.motor_a_drive)
            flag_mismatch($sformatf("motor_a_drive got %b want %b",
                                    motor_a_drive, want.motor_a_drive));
        if (motor_b_drive !== want.motor_b_drive)
            flag_mismatch($sformatf("motor_b_drive got %b want %b",
                                    motor_b_drive, want.motor_b_drive));
        if (lock_led !== want.lock_led)
            flag_mismatch($sformatf("lock_led got %b want %b", lock_led, want.lock_led));
        results_checked++;
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_drive.push_back(predict_drive(drive_item));
                ticks_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_ticks.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    drive_item <= pending_ticks.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // output monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
                check_drive();
            out_ready <= (hold_off_left == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
        end
    end

    // long output hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off_left <= 0;
            stalls_served <= 0;
        end
        else if (stalls_served != stalls_requested)
        begin
            hold_off_left <= HOLD_OFF_CYCLES;
            stalls_served <= stalls_served + 1;
        end
        else if (hold_off_left != 0)
            hold_off_left <= hold_off_left - 1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("TIMEOUT after %0d cycles, %0d of %0d ticks accepted",
                     cycle_count, ticks_accepted, ticks_queued);
            $display("power_window_controller_unit test failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [TICK_REG_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_HOLD_TICKS)
            hold_limit_reg = data;
        else if (idx == REG_JAM_TICKS)
            jam_limit_reg = data;
        cfg_writes++;
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_tick(input in_item_t t);
        pending_ticks.push_back(t);
        ticks_queued++;
    endtask

    // switch levels that persist over ticks, with some fully random noise
    task automatic queue_levels(input int n, input int flip_pct, input int noise_pct);
        in_item_t   t;
        in_item_t   flip;
        logic [7:0] raw;
        repeat (n)
        begin
            if ($urandom_range(99) < noise_pct)
            begin
                raw = 8'($urandom_range(255));
                t = raw;
            end
            else
            begin
                flip = '0;
                flip.drv_a_press      = $urandom_range(99) < flip_pct;
                flip.drv_b_press      = $urandom_range(99) < flip_pct;
                flip.pas_a_press      = $urandom_range(99) < flip_pct;
                flip.pas_b_press      = $urandom_range(99) < flip_pct;
                flip.jam_sensor_level = $urandom_range(99) < flip_pct;
                flip.lock_switch_on   = $urandom_range(99) < 8;
                levels = levels ^ flip;
                levels.limit_a_reached = $urandom_range(99) < LIMIT_PCT;
                levels.limit_b_reached = $urandom_range(99) < LIMIT_PCT;
                t = levels;
            end
            queue_tick(t);
        end
    endtask

    task automatic wait_drained();
        int waited;
        waited = 0;
        while ((ticks_accepted != ticks_queued || expected_drive.size() != 0)
               && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (ticks_accepted != ticks_queued || expected_drive.size() != 0)
            flag_mismatch($sformatf("%0d ticks unsent, %0d results owed after drain",
                                    ticks_queued - ticks_accepted, expected_drive.size()));
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic run_timing_phase(input logic [TICK_REG_W-1:0] hold,
                                    input logic [TICK_REG_W-1:0] jam,
                                    input int n, input int flip_pct,
                                    input int noise_pct, input bit hold_off);
        write_reg(REG_HOLD_TICKS, hold);
        write_reg(REG_JAM_TICKS, jam);
        if ($urandom_range(2) == 0)
            write_reg($urandom_range(1) ? REG_SPARE_3 : REG_SPARE_2,
                      TICK_REG_W'($urandom_range(16'hFFFF)));
        queue_levels(n, flip_pct, noise_pct);
        if (hold_off)
        begin
            @(posedge clk);
            stalls_requested <= stalls_requested + 1;
        end
        wait_drained();
    endtask

    // tick bits: drv_a drv_b pas_a pas_b | lim_a lim_b jam lock
    initial
    begin
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;

        // reset limits: run stays in its hold phase, jam edge takes over
        queue_tick(in_item_t'(8'b0000_0010));
        queue_tick(in_item_t'(8'b1000_0010));
        queue_tick(in_item_t'(8'b1000_0000));
        queue_tick(in_item_t'(8'b0000_0011));
        wait_drained();

        write_reg(REG_HOLD_TICKS, 16'd1);
        write_reg(REG_JAM_TICKS, 16'd3);
        queue_tick(in_item_t'(8'b1111_0010));   // all pressed, driver A wins
        queue_tick(in_item_t'(8'b1000_1010));   // limit ignored in hold, manual
        queue_tick(in_item_t'(8'b1000_0010));
        queue_tick(in_item_t'(8'b1000_1010));   // manual ends on limit
        queue_tick(in_item_t'(8'b0000_0010));
        queue_tick(in_item_t'(8'b0100_0011));   // driver B
        queue_tick(in_item_t'(8'b0000_0011));   // released, automatic
        queue_tick(in_item_t'(8'b0000_0010));
        queue_tick(in_item_t'(8'b0100_0010));   // automatic ends on new press
        queue_tick(in_item_t'(8'b0010_0010));   // passenger A
        queue_tick(in_item_t'(8'b0010_0010));   // manual
        queue_tick(in_item_t'(8'b0000_0010));   // manual ends on release
        queue_tick(in_item_t'(8'b0001_0010));   // passenger B
        queue_tick(in_item_t'(8'b0000_0010));   // automatic
        queue_tick(in_item_t'(8'b0000_0000));   // jam edge
        queue_tick(in_item_t'(8'b0000_0010));
        queue_tick(in_item_t'(8'b0000_0000));   // jam falls again while the jam runs, kept pending
        queue_tick(in_item_t'(8'b0000_0010));   // jam restarts
        queue_tick(in_item_t'(8'b0000_0010));
        queue_tick(in_item_t'(8'b0000_0010));
        queue_tick(in_item_t'(8'b0000_0010));   // jam over, motor muted
        queue_tick(in_item_t'(8'b0000_0010));
        queue_tick(in_item_t'(8'b0000_0110));   // automatic ends on limit B
        wait_drained();

        run_timing_phase(16'd0, 16'd0, 120, 15, 10, 1'b0);
        run_timing_phase(16'hFFFF, 16'hFFFF, 100, 15, 10, 1'b0);
        calm = 1'b1;
        run_timing_phase(16'd2, 16'd5, 200, 12, 5, 1'b0);
        calm = 1'b0;
        run_timing_phase(16'd3, 16'd4, 200, 15, 10, 1'b1);
        repeat (6)
            run_timing_phase(TICK_REG_W'($urandom_range(1, 10)),
                             TICK_REG_W'($urandom_range(1, 16)), 90,
                             $urandom_range(5, 25), $urandom_range(5, 20), 1'b0);
        run_timing_phase(16'd1, 16'd1, 60, 20, 10, 1'b0);

        $display("Checked %0d results from %0d ticks over %0d register writes, %0d mismatches",
                 results_checked, ticks_accepted, cfg_writes, mismatches);
        $display("Runs manual and automatic, jam retries, zero and full-scale limits, %0d-cycle hold-off",
                 HOLD_OFF_CYCLES);
        if (mismatches == 0)
            $display("power_window_controller_unit test passed");
        else
            $display("power_window_controller_unit test failed");
        $finish;
    end

endmodule

### filelist.f
hdl/pwc_pkg.sv
hdl/pwc_ctrl.sv
hdl/power_window_controller_unit.sv
bench/tb_power_window_controller_unit.sv
